// ===== hw/rtl/xlc_pkg.sv =====
// Shared types and character codes for the XML literal classifier.
// No dependencies; used by xlc_recognizer and xml_literal_classifier.

package xlc_pkg;

   localparam int unsigned CharWidth  = 8;
   localparam int unsigned RspBytes   = 1;
   localparam int unsigned RspWidth   = 8 * RspBytes;

   localparam logic [CharWidth-1:0] ChPlus   = 8'h2B;
   localparam logic [CharWidth-1:0] ChMinus  = 8'h2D;
   localparam logic [CharWidth-1:0] ChDot    = 8'h2E;
   localparam logic [CharWidth-1:0] ChZero   = 8'h30;
   localparam logic [CharWidth-1:0] ChOne    = 8'h31;
   localparam logic [CharWidth-1:0] ChNine   = 8'h39;
   localparam logic [CharWidth-1:0] ChUpE    = 8'h45;
   localparam logic [CharWidth-1:0] ChUpF    = 8'h46;
   localparam logic [CharWidth-1:0] ChUpI    = 8'h49;
   localparam logic [CharWidth-1:0] ChUpN    = 8'h4E;
   localparam logic [CharWidth-1:0] ChLowA   = 8'h61;
   localparam logic [CharWidth-1:0] ChLowE   = 8'h65;
   localparam logic [CharWidth-1:0] ChLowF   = 8'h66;
   localparam logic [CharWidth-1:0] ChLowL   = 8'h6C;
   localparam logic [CharWidth-1:0] ChLowR   = 8'h72;
   localparam logic [CharWidth-1:0] ChLowS   = 8'h73;
   localparam logic [CharWidth-1:0] ChLowT   = 8'h74;
   localparam logic [CharWidth-1:0] ChLowU   = 8'h75;

   // Packed so that is_boolean lands in bit 0 of the result word.
   typedef struct packed {
      logic is_double;
      logic is_integer;
      logic is_boolean;
   } verdict_type;

endpackage

// ===== hw/rtl/xlc_recognizer.sv =====
// Three character recognizers (boolean, integer, double) that advance together.
// Depends on xlc_pkg for character codes and the verdict struct.

module xlc_recognizer
   import xlc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [CharWidth-1:0] char_code,
   input  logic                 last_char,
   output verdict_type          verdict
);

   typedef enum logic [3:0] {
      DBL_START = 4'd0,  DBL_SIGN = 4'd1,  DBL_INT  = 4'd2,  DBL_DOT   = 4'd3,
      DBL_FRAC  = 4'd4,  DBL_E    = 4'd5,  DBL_ESIGN = 4'd6, DBL_EXP   = 4'd7,
      DBL_N     = 4'd8,  DBL_NA   = 4'd9,  DBL_NAN  = 4'd10, DBL_I     = 4'd11,
      DBL_IN    = 4'd12, DBL_INF  = 4'd13, DBL_DEAD = 4'd14
   } dbl_phase_type;

   typedef enum logic [1:0] {
      INT_START = 2'd0, INT_SIGN = 2'd1, INT_DIG = 2'd2, INT_DEAD = 2'd3
   } int_phase_type;

   typedef enum logic [3:0] {
      BOOL_START = 4'd0, BOOL_BIT  = 4'd1, BOOL_F   = 4'd2, BOOL_FA   = 4'd3,
      BOOL_FAL   = 4'd4, BOOL_FALS = 4'd5, BOOL_FALSE = 4'd6, BOOL_T  = 4'd7,
      BOOL_TR    = 4'd8, BOOL_TRU  = 4'd9, BOOL_TRUE = 4'd10, BOOL_DEAD = 4'd15
   } bool_phase_type;

   dbl_phase_type  dbl_phase_ff,  dbl_phase_in,  dbl_next;
   int_phase_type  int_phase_ff,  int_phase_in,  int_next;
   bool_phase_type bool_phase_ff, bool_phase_in, bool_next;
   logic           is_dig, is_sign, is_exp;

   assign is_dig  = (char_code >= ChZero) && (char_code <= ChNine);
   assign is_sign = (char_code == ChPlus) || (char_code == ChMinus);
   assign is_exp  = (char_code == ChUpE) || (char_code == ChLowE);

   always_comb begin
      dbl_next = DBL_DEAD;
      case (dbl_phase_ff)
         DBL_START: begin
            if (is_sign)                     dbl_next = DBL_SIGN;
            else if (is_dig)                 dbl_next = DBL_INT;
            else if (char_code == ChDot)     dbl_next = DBL_DOT;
            else if (char_code == ChUpN)     dbl_next = DBL_N;
            else if (char_code == ChUpI)     dbl_next = DBL_I;
         end
         DBL_SIGN: begin
            if (is_dig)                      dbl_next = DBL_INT;
            else if (char_code == ChDot)     dbl_next = DBL_DOT;
            else if (char_code == ChUpI)     dbl_next = DBL_I;
         end
         DBL_INT: begin
            if (is_dig)                      dbl_next = DBL_INT;
            else if (char_code == ChDot)     dbl_next = DBL_FRAC;
            else if (is_exp)                 dbl_next = DBL_E;
         end
         DBL_DOT:   if (is_dig) dbl_next = DBL_FRAC;
         DBL_FRAC: begin
            if (is_dig)                      dbl_next = DBL_FRAC;
            else if (is_exp)                 dbl_next = DBL_E;
         end
         DBL_E: begin
            if (is_sign)                     dbl_next = DBL_ESIGN;
            else if (is_dig)                 dbl_next = DBL_EXP;
         end
         DBL_ESIGN, DBL_EXP: if (is_dig) dbl_next = DBL_EXP;
         DBL_N:  if (char_code == ChLowA) dbl_next = DBL_NA;
         DBL_NA: if (char_code == ChUpN)  dbl_next = DBL_NAN;
         DBL_I:  if (char_code == ChUpN)  dbl_next = DBL_IN;
         DBL_IN: if (char_code == ChUpF)  dbl_next = DBL_INF;
         default: dbl_next = DBL_DEAD;
      endcase
   end

   always_comb begin
      int_next = INT_DEAD;
      case (int_phase_ff)
         INT_START: begin
            if (is_sign)     int_next = INT_SIGN;
            else if (is_dig) int_next = INT_DIG;
         end
         INT_SIGN, INT_DIG: if (is_dig) int_next = INT_DIG;
         default: int_next = INT_DEAD;
      endcase
   end

   always_comb begin
      bool_next = BOOL_DEAD;
      case (bool_phase_ff)
         BOOL_START: begin
            if ((char_code == ChZero) || (char_code == ChOne)) bool_next = BOOL_BIT;
            else if (char_code == ChLowF)                     bool_next = BOOL_F;
            else if (char_code == ChLowT)                     bool_next = BOOL_T;
         end
         BOOL_F:    if (char_code == ChLowA) bool_next = BOOL_FA;
         BOOL_FA:   if (char_code == ChLowL) bool_next = BOOL_FAL;
         BOOL_FAL:  if (char_code == ChLowS) bool_next = BOOL_FALS;
         BOOL_FALS: if (char_code == ChLowE) bool_next = BOOL_FALSE;
         BOOL_T:    if (char_code == ChLowR) bool_next = BOOL_TR;
         BOOL_TR:   if (char_code == ChLowU) bool_next = BOOL_TRU;
         BOOL_TRU:  if (char_code == ChLowE) bool_next = BOOL_TRUE;
         default:   bool_next = BOOL_DEAD;
      endcase
   end

   always_comb begin
      verdict.is_double  = (dbl_next inside {DBL_INT, DBL_FRAC, DBL_EXP, DBL_NAN, DBL_INF});
      verdict.is_integer = (int_next == INT_DIG);
      verdict.is_boolean = (bool_next inside {BOOL_BIT, BOOL_FALSE, BOOL_TRUE});
   end

   // The final character of a literal sends every recognizer back to its start.
   always_comb begin
      dbl_phase_in  = dbl_phase_ff;
      int_phase_in  = int_phase_ff;
      bool_phase_in = bool_phase_ff;
      if (step) begin
         dbl_phase_in  = last_char ? DBL_START  : dbl_next;
         int_phase_in  = last_char ? INT_START  : int_next;
         bool_phase_in = last_char ? BOOL_START : bool_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dbl_phase_ff  <= DBL_START;
         int_phase_ff  <= INT_START;
         bool_phase_ff <= BOOL_START;
      end else begin
         dbl_phase_ff  <= dbl_phase_in;
         int_phase_ff  <= int_phase_in;
         bool_phase_ff <= bool_phase_in;
      end
   end

endmodule

// ===== hw/rtl/xml_literal_classifier.sv =====
// Top level of the XML literal classifier: input register, recognizers, result register.
// Depends on xlc_pkg and xlc_recognizer.

// The block takes one character word per cycle, with tlast on the final character of a
// literal. After that final character it returns one result word that tells whether the
// literal is a boolean, an integer and an XML double. Characters that are not final give
// no result. A character is held in an input register. When consumed it advances the
// three recognizers and, if it is final, loads the result register. The result word is
// therefore valid from the edge right after the final character is taken, unless an
// earlier result word has not yet been taken. Throughput is one character per cycle.
// Only a final character waits in the input register, and only while the previous result
// word is still pending.

module xml_literal_classifier
   import xlc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [CharWidth-1:0] req_tdata,   // [7:0] char_code
   input  logic                 req_tlast,   // last_char
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RspWidth-1:0]  rsp_tdata    // [0] is_boolean, [1] is_integer, [2] is_double
);

   logic                 in_valid_ff, in_valid_in;
   logic [CharWidth-1:0] in_char_ff,  in_char_in;
   logic                 in_last_ff,  in_last_in;
   logic                 out_valid_ff, out_valid_in;
   verdict_type          out_verdict_ff, out_verdict_in;
   verdict_type          verdict;
   logic                 out_free;
   logic                 consume;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign consume    = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || consume;

   xlc_recognizer u_recognizer (
      .clock     (clock),
      .reset     (reset),
      .step      (consume),
      .char_code (in_char_ff),
      .last_char (in_last_ff),
      .verdict   (verdict)
   );

   always_comb begin
      in_valid_in    = in_valid_ff;
      in_char_in     = in_char_ff;
      in_last_in     = in_last_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_char_in  = req_tdata;
         in_last_in  = req_tlast;
      end
      out_valid_in   = out_valid_ff && !rsp_tready;
      out_verdict_in = out_verdict_ff;
      if (consume && in_last_ff) begin
         out_valid_in   = 1'b1;
         out_verdict_in = verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_char_ff     <= in_char_in;
      in_last_ff     <= in_last_in;
      out_verdict_ff <= out_verdict_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspWidth - $bits(verdict_type)){1'b0}}, out_verdict_ff};

   // Every integer literal is also a double literal.
   a_int_is_double: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[1] || rsp_tdata[2]))
      else $error("integer verdict without double verdict");

   // A result word appears only after a final character has been processed.
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(consume && in_last_ff))
      else $error("result word without a final character");

   // A final character blocked by a waiting result stays in the input register.
   a_last_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_last_ff && rsp_tvalid && !rsp_tready) |=>
         (in_valid_ff && in_last_ff))
      else $error("final character lost while result stalled");

   // An empty input register always takes a new word.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("input register empty but not ready");

endmodule
